/* src/csov_pkg.sv */
package csov_pkg;

  // Operation codes carried by an input word.
  typedef enum logic [2:0] {
    OP_FRAME_WRITE = 3'd0,
    OP_FRAME_READ  = 3'd1,
    OP_SPRITE_LOAD = 3'd2,
    OP_MOVE        = 3'd3,
    OP_SHOW        = 3'd4,
    OP_HIDE        = 3'd5,
    OP_FLUSH       = 3'd6
  } op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_RESTORE,
    ST_DRAWSET,
    ST_DRAW,
    ST_DONE
  } state_t;

  // Configuration register indexes and port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_HEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_PRESENT = 3'd4;

  // Register values after reset.
  localparam logic [6:0] RST_SCREEN_WIDTH  = 7'd64;
  localparam logic [6:0] RST_SCREEN_HEIGHT = 7'd64;
  localparam logic [4:0] RST_CURSOR_WIDTH  = 5'd16;
  localparam logic [4:0] RST_CURSOR_HEIGHT = 5'd16;

  // Input word.
  typedef struct packed {
    op_t        op;
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [7:0] pixel_value;
  } item_t;

  // Result word.
  typedef struct packed {
    logic [7:0] read_pixel;
    logic       save_active;
  } result_t;

  // Configuration register file as seen by the sequencer.
  typedef struct packed {
    logic [6:0] screen_width;
    logic [6:0] screen_height;
    logic [4:0] cursor_width;
    logic [4:0] cursor_height;
    logic       cursor_present;
  } cfg_t;

endpackage

/* src/csov_ram.sv */
module csov_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/csov_ctrl.sv */
module csov_ctrl
  import csov_pkg::*;
#(
  parameter int FRAME_W    = 64,
  parameter int FRAME_H    = 64,
  parameter int CURSOR_MAX = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  input  item_t                                     item,
  input  cfg_t                                      cfg,
  output logic                                      busy,
  output logic                                      done,
  output result_t                                   result,
  output logic                                      frame_we,
  output logic [$clog2(FRAME_W*FRAME_H)-1:0]        frame_waddr,
  output logic [7:0]                                frame_wdata,
  output logic [$clog2(FRAME_W*FRAME_H)-1:0]        frame_raddr,
  input  logic [7:0]                                frame_rdata,
  output logic                                      sprite_we,
  output logic [$clog2(CURSOR_MAX*CURSOR_MAX)-1:0]  sprite_waddr,
  output logic [7:0]                                sprite_wdata,
  output logic [$clog2(CURSOR_MAX*CURSOR_MAX)-1:0]  sprite_raddr,
  input  logic [7:0]                                sprite_rdata,
  output logic                                      save_we,
  output logic [$clog2(CURSOR_MAX*CURSOR_MAX)-1:0]  save_waddr,
  output logic [7:0]                                save_wdata,
  output logic [$clog2(CURSOR_MAX*CURSOR_MAX)-1:0]  save_raddr,
  input  logic [7:0]                                save_rdata
);

  localparam int FA_W   = $clog2(FRAME_W * FRAME_H);
  localparam int SA_W   = $clog2(CURSOR_MAX * CURSOR_MAX);
  localparam int CI_W   = $clog2(CURSOR_MAX);
  localparam int CNT_W  = $clog2(CURSOR_MAX + 1);
  localparam int DMAX   = (FRAME_W > FRAME_H) ? FRAME_W : FRAME_H;
  localparam int DIM_W  = (DMAX > 127) ? $clog2(DMAX + 1) : 7;
  localparam logic [FA_W-1:0] CLR_LAST = FA_W'(FRAME_W * FRAME_H - 1);

  // Control state.
  state_t            state, state_next;
  logic [FA_W-1:0]   clr_addr, clr_addr_next;
  logic              save_valid, save_valid_next;
  logic              hidden, hidden_next;
  logic              draw_req, draw_req_next;
  logic              pend_restore, pend_restore_next;
  logic              pend_draw, pend_draw_next;
  logic [5:0]        cursor_x, cursor_x_next;
  logic [5:0]        cursor_y, cursor_y_next;
  logic [5:0]        save_ox, save_ox_next;
  logic [5:0]        save_oy, save_oy_next;
  logic [CNT_W-1:0]  save_cols, save_cols_next;
  logic [CNT_W-1:0]  save_rows, save_rows_next;

  // Working registers without reset.
  op_t               op_q, op_q_next;
  logic [5:0]        x_q, x_q_next;
  logic [5:0]        y_q, y_q_next;
  logic [7:0]        pv_q, pv_q_next;
  logic [7:0]        rd_q, rd_q_next;
  logic [CI_W-1:0]   col, col_next;
  logic [CI_W-1:0]   row, row_next;
  logic [FA_W-1:0]   fbase, fbase_next;
  logic [SA_W-1:0]   sbase, sbase_next;
  logic [FA_W-1:0]   wr_faddr, wr_faddr_next;
  logic [SA_W-1:0]   wr_saddr, wr_saddr_next;

  // Combinational helpers.
  logic [DIM_W-1:0]  sw_raw, sh_raw, cw_raw, ch_raw;
  logic [DIM_W-1:0]  eff_sw, eff_sh, eff_cw, eff_ch;
  logic [DIM_W-1:0]  room_x, room_y;
  logic [CNT_W-1:0]  clip_cols, clip_rows;
  logic              in_range, sp_range;
  logic [5:0]        mul_x, mul_y;
  logic [FA_W-1:0]   mul_addr;
  logic [SA_W-1:0]   load_addr;
  logic [FA_W-1:0]   cur_faddr;
  logic [SA_W-1:0]   cur_saddr;
  logic              last_col, last_row;
  logic              restore_begin;

  // Saturate the registers to their meaningful ranges.
  always_comb begin
    sw_raw = DIM_W'(cfg.screen_width);
    sh_raw = DIM_W'(cfg.screen_height);
    cw_raw = DIM_W'(cfg.cursor_width);
    ch_raw = DIM_W'(cfg.cursor_height);
    eff_sw = (sw_raw == '0) ? DIM_W'(1) :
             ((sw_raw > DIM_W'(FRAME_W)) ? DIM_W'(FRAME_W) : sw_raw);
    eff_sh = (sh_raw == '0) ? DIM_W'(1) :
             ((sh_raw > DIM_W'(FRAME_H)) ? DIM_W'(FRAME_H) : sh_raw);
    eff_cw = (cw_raw == '0) ? DIM_W'(1) :
             ((cw_raw > DIM_W'(CURSOR_MAX)) ? DIM_W'(CURSOR_MAX) : cw_raw);
    eff_ch = (ch_raw == '0) ? DIM_W'(1) :
             ((ch_raw > DIM_W'(CURSOR_MAX)) ? DIM_W'(CURSOR_MAX) : ch_raw);
  end

  // Clip the sprite at the right and bottom edges of the screen.
  always_comb begin
    room_x = eff_sw - DIM_W'(cursor_x);
    room_y = eff_sh - DIM_W'(cursor_y);
    if (DIM_W'(cursor_x) >= eff_sw) begin
      clip_cols = '0;
    end else begin
      clip_cols = CNT_W'((eff_cw > room_x) ? room_x : eff_cw);
    end
    if (DIM_W'(cursor_y) >= eff_sh) begin
      clip_rows = '0;
    end else begin
      clip_rows = CNT_W'((eff_ch > room_y) ? room_y : eff_ch);
    end
  end

  // Range checks for direct frame and sprite access.
  assign in_range = (DIM_W'(x_q) < eff_sw) && (DIM_W'(y_q) < eff_sh);
  assign sp_range = ({1'b0, x_q} < 7'(CURSOR_MAX)) && ({1'b0, y_q} < 7'(CURSOR_MAX));

  // Shared address unit: row times frame width plus column, with the origin
  // picked by the current step.
  always_comb begin
    if (state == ST_DRAWSET) begin
      mul_x = cursor_x;
      mul_y = cursor_y;
    end else if (op_q == OP_FRAME_WRITE || op_q == OP_FRAME_READ) begin
      mul_x = x_q;
      mul_y = y_q;
    end else begin
      mul_x = save_ox;
      mul_y = save_oy;
    end
  end

  assign mul_addr  = FA_W'(FA_W'(mul_y) * FA_W'(FRAME_W)) + FA_W'(mul_x);
  assign load_addr = SA_W'(SA_W'(y_q) * SA_W'(CURSOR_MAX)) + SA_W'(x_q);
  assign cur_faddr = fbase + FA_W'(col);
  assign cur_saddr = sbase + SA_W'(col);
  assign last_col  = (col == CI_W'(save_cols - CNT_W'(1)));
  assign last_row  = (row == CI_W'(save_rows - CNT_W'(1)));

  // Sequencer: next state, memory controls and register updates.
  always_comb begin
    state_next        = state;
    clr_addr_next     = clr_addr;
    save_valid_next   = save_valid;
    hidden_next       = hidden;
    draw_req_next     = draw_req;
    cursor_x_next     = cursor_x;
    cursor_y_next     = cursor_y;
    save_ox_next      = save_ox;
    save_oy_next      = save_oy;
    save_cols_next    = save_cols;
    save_rows_next    = save_rows;
    op_q_next         = op_q;
    x_q_next          = x_q;
    y_q_next          = y_q;
    pv_q_next         = pv_q;
    rd_q_next         = rd_q;
    col_next          = col;
    row_next          = row;
    fbase_next        = fbase;
    sbase_next        = sbase;
    pend_restore_next = 1'b0;
    pend_draw_next    = 1'b0;
    wr_faddr_next     = cur_faddr;
    wr_saddr_next     = cur_saddr;
    restore_begin     = 1'b0;

    frame_we     = 1'b0;
    frame_waddr  = wr_faddr;
    frame_wdata  = save_rdata;
    frame_raddr  = cur_faddr;
    sprite_we    = 1'b0;
    sprite_waddr = load_addr;
    sprite_wdata = pv_q;
    sprite_raddr = cur_saddr;
    save_we      = 1'b0;
    save_waddr   = wr_saddr;
    save_wdata   = frame_rdata;
    save_raddr   = cur_saddr;

    // Writes that complete a pixel read in the previous cycle.
    if (pend_restore) begin
      frame_we    = 1'b1;
      frame_wdata = save_rdata;
    end
    if (pend_draw) begin
      save_we     = 1'b1;
      frame_we    = (sprite_rdata != 8'd0);
      frame_wdata = sprite_rdata;
    end

    case (state)
      ST_CLEAR: begin
        frame_we      = 1'b1;
        frame_waddr   = clr_addr;
        frame_wdata   = 8'd0;
        clr_addr_next = clr_addr + FA_W'(1);
        if (clr_addr == CLR_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          op_q_next  = item.op;
          x_q_next   = item.pos_x;
          y_q_next   = item.pos_y;
          pv_q_next  = item.pixel_value;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rd_q_next  = 8'd0;
        state_next = ST_DONE;
        case (op_q)
          OP_FRAME_WRITE: begin
            if (in_range) begin
              frame_we    = 1'b1;
              frame_waddr = mul_addr;
              frame_wdata = pv_q;
            end
          end
          OP_FRAME_READ: begin
            frame_raddr = mul_addr;
            state_next  = ST_READ;
          end
          OP_SPRITE_LOAD: begin
            sprite_we = sp_range;
          end
          OP_MOVE: begin
            cursor_x_next = x_q;
            cursor_y_next = y_q;
            draw_req_next = 1'b1;
            restore_begin = 1'b1;
          end
          OP_SHOW: begin
            hidden_next   = 1'b0;
            draw_req_next = 1'b1;
            restore_begin = 1'b1;
          end
          OP_HIDE: begin
            hidden_next   = 1'b1;
            draw_req_next = 1'b0;
            restore_begin = 1'b1;
          end
          OP_FLUSH: begin
            save_valid_next = 1'b0;
            hidden_next     = 1'b1;
          end
          default: begin
          end
        endcase
        // Put back the saved background before anything is drawn.
        if (restore_begin) begin
          save_valid_next = 1'b0;
          col_next        = '0;
          row_next        = '0;
          sbase_next      = '0;
          fbase_next      = mul_addr;
          if (save_valid && save_cols != '0 && save_rows != '0) begin
            state_next = ST_RESTORE;
          end else if (draw_req_next) begin
            state_next = ST_DRAWSET;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_READ: begin
        rd_q_next  = in_range ? frame_rdata : 8'd0;
        state_next = ST_DONE;
      end
      ST_RESTORE: begin
        pend_restore_next = 1'b1;
        if (last_col) begin
          col_next   = '0;
          row_next   = row + CI_W'(1);
          fbase_next = fbase + FA_W'(FRAME_W);
          sbase_next = sbase + SA_W'(CURSOR_MAX);
          if (last_row) begin
            state_next = draw_req ? ST_DRAWSET : ST_DONE;
          end
        end else begin
          col_next = col + CI_W'(1);
        end
      end
      ST_DRAWSET: begin
        state_next = ST_DONE;
        if (cfg.cursor_present && !hidden) begin
          save_valid_next = 1'b1;
          save_ox_next    = cursor_x;
          save_oy_next    = cursor_y;
          save_cols_next  = clip_cols;
          save_rows_next  = clip_rows;
          col_next        = '0;
          row_next        = '0;
          sbase_next      = '0;
          fbase_next      = mul_addr;
          if (clip_cols != '0 && clip_rows != '0) begin
            state_next = ST_DRAW;
          end
        end
      end
      ST_DRAW: begin
        pend_draw_next = 1'b1;
        if (last_col) begin
          col_next   = '0;
          row_next   = row + CI_W'(1);
          fbase_next = fbase + FA_W'(FRAME_W);
          sbase_next = sbase + SA_W'(CURSOR_MAX);
          if (last_row) begin
            state_next = ST_DONE;
          end
        end else begin
          col_next = col + CI_W'(1);
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      save_valid   <= 1'b0;
      hidden       <= 1'b0;
      draw_req     <= 1'b0;
      pend_restore <= 1'b0;
      pend_draw    <= 1'b0;
      cursor_x     <= '0;
      cursor_y     <= '0;
      save_ox      <= '0;
      save_oy      <= '0;
      save_cols    <= '0;
      save_rows    <= '0;
    end else begin
      state        <= state_next;
      clr_addr     <= clr_addr_next;
      save_valid   <= save_valid_next;
      hidden       <= hidden_next;
      draw_req     <= draw_req_next;
      pend_restore <= pend_restore_next;
      pend_draw    <= pend_draw_next;
      cursor_x     <= cursor_x_next;
      cursor_y     <= cursor_y_next;
      save_ox      <= save_ox_next;
      save_oy      <= save_oy_next;
      save_cols    <= save_cols_next;
      save_rows    <= save_rows_next;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    op_q     <= op_q_next;
    x_q      <= x_q_next;
    y_q      <= y_q_next;
    pv_q     <= pv_q_next;
    rd_q     <= rd_q_next;
    col      <= col_next;
    row      <= row_next;
    fbase    <= fbase_next;
    sbase    <= sbase_next;
    wr_faddr <= wr_faddr_next;
    wr_saddr <= wr_saddr_next;
  end

  // Handshake and result word.
  assign busy               = (state != ST_IDLE);
  assign done               = (state == ST_DONE);
  assign result.read_pixel  = rd_q;
  assign result.save_active = save_valid;

endmodule

/* src/cursor_sprite_overlay.sv */
// Software cursor with a save-under area over an 8-bit frame store. After
// reset the block clears the frame store, one pixel per cycle, and holds busy
// high until the clear is complete. An input word is taken when start is high
// and busy is low; its one result word appears on result with done high for a
// single cycle and must be captured then, since the receiver cannot stall.
// Frame write, sprite load, flush and unused codes pass through the execute
// state to done; frame read adds a read state. Move and show first restore the
// saved area R (columns times rows, zero if nothing is saved), then set up and
// draw the clipped sprite area D (zero when nothing is drawn); hide only restores
// R. Every pixel goes through the single frame store write port, one per cycle.
// busy drops the cycle after done.
// Configuration writes are taken at any edge with cfg_we high and should only
// be made while the block is idle.
module cursor_sprite_overlay
  import csov_pkg::*;
#(
  parameter int FRAME_W    = 64,
  parameter int FRAME_H    = 64,
  parameter int CURSOR_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FDEPTH = FRAME_W * FRAME_H;
  localparam int SDEPTH = CURSOR_MAX * CURSOR_MAX;
  localparam int FA_W   = $clog2(FDEPTH);
  localparam int SA_W   = $clog2(SDEPTH);

  cfg_t            cfg;
  logic            frame_we, sprite_we, save_we;
  logic [FA_W-1:0] frame_waddr, frame_raddr;
  logic [SA_W-1:0] sprite_waddr, sprite_raddr, save_waddr, save_raddr;
  logic [7:0]      frame_wdata, frame_rdata;
  logic [7:0]      sprite_wdata, sprite_rdata;
  logic [7:0]      save_wdata, save_rdata;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width   <= RST_SCREEN_WIDTH;
      cfg.screen_height  <= RST_SCREEN_HEIGHT;
      cfg.cursor_width   <= RST_CURSOR_WIDTH;
      cfg.cursor_height  <= RST_CURSOR_HEIGHT;
      cfg.cursor_present <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:   cfg.screen_width   <= cfg_data[6:0];
        REG_SCREEN_HEIGHT:  cfg.screen_height  <= cfg_data[6:0];
        REG_CURSOR_WIDTH:   cfg.cursor_width   <= cfg_data[4:0];
        REG_CURSOR_HEIGHT:  cfg.cursor_height  <= cfg_data[4:0];
        REG_CURSOR_PRESENT: cfg.cursor_present <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and address unit.
  csov_ctrl #(
    .FRAME_W    (FRAME_W),
    .FRAME_H    (FRAME_H),
    .CURSOR_MAX (CURSOR_MAX)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .cfg          (cfg),
    .busy         (busy),
    .done         (done),
    .result       (result),
    .frame_we     (frame_we),
    .frame_waddr  (frame_waddr),
    .frame_wdata  (frame_wdata),
    .frame_raddr  (frame_raddr),
    .frame_rdata  (frame_rdata),
    .sprite_we    (sprite_we),
    .sprite_waddr (sprite_waddr),
    .sprite_wdata (sprite_wdata),
    .sprite_raddr (sprite_raddr),
    .sprite_rdata (sprite_rdata),
    .save_we      (save_we),
    .save_waddr   (save_waddr),
    .save_wdata   (save_wdata),
    .save_raddr   (save_raddr),
    .save_rdata   (save_rdata)
  );

  // Frame store.
  csov_ram #(
    .WIDTH (8),
    .DEPTH (FDEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  // Cursor sprite store.
  csov_ram #(
    .WIDTH (8),
    .DEPTH (SDEPTH)
  ) u_sprite (
    .clk   (clk),
    .we    (sprite_we),
    .waddr (sprite_waddr),
    .wdata (sprite_wdata),
    .raddr (sprite_raddr),
    .rdata (sprite_rdata)
  );

  // Save-under store.
  csov_ram #(
    .WIDTH (8),
    .DEPTH (SDEPTH)
  ) u_save (
    .clk   (clk),
    .we    (save_we),
    .waddr (save_waddr),
    .wdata (save_wdata),
    .raddr (save_raddr),
    .rdata (save_rdata)
  );

`ifndef SYNTH
  // A result word is only given while an accepted word is in work.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without a word in work");

  // An accepted word never completes in the very next cycle.
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result one cycle after accept");

  // The block goes busy right after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("not busy after accept");
`endif

endmodule
